// ===== sv/msbs_pkg.sv =====
// Shared types and field widths for the matrix store bilinear sampler.
package msbs_pkg;

   // Fixed widths of the transaction fields and configuration registers.
   localparam int OP_W   = 2;
   localparam int IDX_W  = 6;
   localparam int VAL_W  = 16;
   localparam int POS_W  = 14;
   localparam int CFG_W  = 7;
   localparam int RES_W  = 16;
   localparam int CSR_AW = 1;

   // Request payload width: row, col, value, row_pos, col_pos.
   localparam int REQ_DATA_W = 2 * IDX_W + VAL_W + 2 * POS_W;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
   localparam logic [OP_W-1:0] OP_READ   = 2'd1;
   localparam logic [OP_W-1:0] OP_SAMPLE = 2'd2;

   // Register indexes.
   localparam logic [CSR_AW-1:0] CSR_ROWS = 1'b0;
   localparam logic [CSR_AW-1:0] CSR_COLS = 1'b1;

   // Number of bits that select one of the four neighbor cells.
   localparam int CELL_BITS = 2;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic                 capture;
      logic                 rd_en;
      logic [CELL_BITS-1:0] nbr;
      logic                 mul_en;
      logic                 acc_en;
      logic                 load_out;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic go_read;
      logic go_sample;
      logic out_free;
   } status_type;

endpackage

// ===== sv/matrix_store_bilinear_sampler.sv =====
// Top level of the matrix store bilinear sampler.
//
// A matrix of signed samples sits in a store with one write port and one read
// port. Each request transaction carries one operation in req_tuser: write an
// element, read an element, or take a bilinear sample at fixed-point row and
// column positions. Every request gives exactly one response transaction with
// the value in rsp_tdata and the in-range flag in rsp_tuser.
// The csr_ port sets the number of rows and columns in use; write it only
// while the block is idle.
// A new request is taken only after the work on the previous one has ended.
// A bilinear sample reads its four neighbors one after another through the
// one store read port, then drains the multiply and accumulate.
// The response sits in an output register, so a new request is taken while
// that response waits.
// A stalled receiver holds the response; finished work then waits, and no
// new request is taken until the output register frees up.
// Reset clears the control logic and sets both size registers to 64; the
// store keeps its contents, which are undefined until written.
module matrix_store_bilinear_sampler
   import msbs_pkg::*;
#(
   parameter int MAX_ROWS    = 64,
   parameter int MAX_COLS    = 64,
   parameter int SAMPLE_BITS = 16,
   parameter int FRAC_BITS   = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   // Configuration write port.
   input  logic                  csr_wen,
   input  logic [CSR_AW-1:0]     csr_addr,
   input  logic [CFG_W-1:0]      csr_wdata,
   // Request channel.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // row, col, value, row_pos, col_pos
   input  logic [OP_W-1:0]       req_tuser,  // op
   // Response channel.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RES_W-1:0]      rsp_tdata,  // result
   output logic                  rsp_tuser   // ok
);

   cmd_type    cmd;
   status_type status;

   // Request payload fields.
   logic [IDX_W-1:0]        req_row;
   logic [IDX_W-1:0]        req_col;
   logic signed [VAL_W-1:0] req_value;
   logic [POS_W-1:0]        req_row_pos;
   logic [POS_W-1:0]        req_col_pos;
   logic signed [RES_W-1:0] rsp_result;

   assign req_row     = req_tdata[IDX_W-1:0];
   assign req_col     = req_tdata[2*IDX_W-1:IDX_W];
   assign req_value   = req_tdata[2*IDX_W+VAL_W-1:2*IDX_W];
   assign req_row_pos = req_tdata[2*IDX_W+VAL_W+POS_W-1:2*IDX_W+VAL_W];
   assign req_col_pos = req_tdata[REQ_DATA_W-1:2*IDX_W+VAL_W+POS_W];
   assign rsp_tdata   = rsp_result;

   // Controller.
   msbs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Datapath.
   msbs_dpath #(
      .MAX_ROWS    (MAX_ROWS),
      .MAX_COLS    (MAX_COLS),
      .SAMPLE_BITS (SAMPLE_BITS),
      .FRAC_BITS   (FRAC_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_wen     (csr_wen),
      .csr_addr    (csr_addr),
      .csr_wdata   (csr_wdata),
      .req_op      (req_tuser),
      .req_row     (req_row),
      .req_col     (req_col),
      .req_value   (req_value),
      .req_row_pos (req_row_pos),
      .req_col_pos (req_col_pos),
      .cmd         (cmd),
      .status      (status),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_result  (rsp_result),
      .rsp_ok      (rsp_tuser)
   );

`ifndef SYNTHESIS
   // One transaction at a time: an accepted request makes the block busy.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted while previous work still in progress");

   // A response is only loaded when the output register is free.
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> status.out_free)
      else $error("response loaded over a pending response");

   // Accumulation always follows a multiply of the previous cycle.
   a_acc_after_mul: assert property (@(posedge clock) disable iff (reset)
      cmd.acc_en |-> $past(cmd.mul_en))
      else $error("accumulate without preceding multiply");

   // An out-of-range response carries a zero value.
   a_zero_when_bad: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == '0))
      else $error("nonzero value on out-of-range response");
`endif

endmodule

// ===== sv/msbs_ctrl.sv =====
// Controller state machine of the matrix store bilinear sampler.
module msbs_ctrl
   import msbs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   // State codes.
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_READ   = 2'd1;
   localparam logic [1:0] ST_SAMPLE = 2'd2;
   localparam logic [1:0] ST_DONE   = 2'd3;

   // Step counts of the sample sequence: four reads, multiply, accumulate.
   localparam logic [2:0] RD_LAST   = 3'd3;
   localparam logic [2:0] MUL_FIRST = 3'd1;
   localparam logic [2:0] MUL_LAST  = 3'd4;
   localparam logic [2:0] ACC_FIRST = 3'd2;
   localparam logic [2:0] ACC_LAST  = 3'd5;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic [2:0] cnt_ff;
   logic [2:0] cnt_in;

   // Next state and command decode.
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               cnt_in      = '0;
               priority if (status.go_read) begin
                  state_in = ST_READ;
               end else if (status.go_sample) begin
                  state_in = ST_SAMPLE;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_DONE;
         end
         ST_SAMPLE: begin
            cmd.rd_en  = (cnt_ff <= RD_LAST);
            cmd.nbr    = cnt_ff[CELL_BITS-1:0];
            cmd.mul_en = (cnt_ff >= MUL_FIRST) && (cnt_ff <= MUL_LAST);
            cmd.acc_en = (cnt_ff >= ACC_FIRST);
            if (cnt_ff == ACC_LAST) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + 3'd1;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and step counter registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ===== sv/msbs_dpath.sv =====
// Datapath of the matrix store bilinear sampler: store, weights, accumulator.
module msbs_dpath
   import msbs_pkg::*;
#(
   parameter int MAX_ROWS    = 64,
   parameter int MAX_COLS    = 64,
   parameter int SAMPLE_BITS = 16,
   parameter int FRAC_BITS   = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_wen,
   input  logic [CSR_AW-1:0]       csr_addr,
   input  logic [CFG_W-1:0]        csr_wdata,
   input  logic [OP_W-1:0]         req_op,
   input  logic [IDX_W-1:0]        req_row,
   input  logic [IDX_W-1:0]        req_col,
   input  logic signed [VAL_W-1:0] req_value,
   input  logic [POS_W-1:0]        req_row_pos,
   input  logic [POS_W-1:0]        req_col_pos,
   input  cmd_type                 cmd,
   output status_type              status,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic signed [RES_W-1:0] rsp_result,
   output logic                    rsp_ok
);

   localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

   // Derived widths.
   localparam int RW    = $clog2(MAX_ROWS);
   localparam int CW    = $clog2(MAX_COLS);
   localparam int AW    = RW + CW;
   localparam int DEPTH = MAX_ROWS * (2 ** CW);
   localparam int NRW   = ($clog2(MAX_ROWS + 1) > CFG_W) ? $clog2(MAX_ROWS + 1) : CFG_W;
   localparam int NCW   = ($clog2(MAX_COLS + 1) > CFG_W) ? $clog2(MAX_COLS + 1) : CFG_W;
   localparam int PXR   = (NRW + FRAC_BITS > POS_W) ? NRW + FRAC_BITS : POS_W;
   localparam int PXC   = (NCW + FRAC_BITS > POS_W) ? NCW + FRAC_BITS : POS_W;
   localparam int WTW   = FRAC_BITS + 1;
   localparam int WPW   = 2 * WTW;
   localparam int PRW   = SAMPLE_BITS + 2 * FRAC_BITS + 1;
   localparam int ACCW  = (PRW > RES_W) ? PRW : RES_W;
   localparam int EXW   = (SAMPLE_BITS > RES_W) ? SAMPLE_BITS : RES_W;

   localparam logic [NRW-1:0] ROWS_CAP = NRW'(MAX_ROWS);
   localparam logic [NCW-1:0] COLS_CAP = NCW'(MAX_COLS);
   localparam logic [WTW-1:0] WT_ONE   = {1'b1, {FRAC_BITS{1'b0}}};

   // Configuration registers.
   logic [CFG_W-1:0] rows_ff;
   logic [CFG_W-1:0] rows_in;
   logic [CFG_W-1:0] cols_ff;
   logic [CFG_W-1:0] cols_in;

   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_wen) begin
         unique case (csr_addr)
            CSR_ROWS: rows_in = csr_wdata;
            CSR_COLS: cols_in = csr_wdata;
            default:  rows_in = rows_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= CFG_RESET;
         cols_ff <= CFG_RESET;
      end else begin
         rows_ff <= rows_in;
         cols_ff <= cols_in;
      end
   end

   // Effective size, clamped to the store dimensions.
   logic [NRW-1:0] rows_x;
   logic [NCW-1:0] cols_x;
   logic [NRW-1:0] nr;
   logic [NCW-1:0] nc;

   assign rows_x = NRW'(rows_ff);
   assign cols_x = NCW'(cols_ff);
   assign nr     = (rows_x > ROWS_CAP) ? ROWS_CAP : rows_x;
   assign nc     = (cols_x > COLS_CAP) ? COLS_CAP : cols_x;

   // Range check for element read and write.
   logic [NRW-1:0] row_x;
   logic [NCW-1:0] col_x;
   logic           rw_ok;
   logic [RW-1:0]  row_idx;
   logic [CW-1:0]  col_idx;

   assign row_x   = NRW'(req_row);
   assign col_x   = NCW'(req_col);
   assign rw_ok   = (row_x < nr) && (col_x < nc);
   assign row_idx = row_x[RW-1:0];
   assign col_idx = col_x[CW-1:0];

   // Range check and neighbor split for bilinear sampling.
   logic [PXR-1:0]       rp_x;
   logic [PXC-1:0]       cp_x;
   logic [NRW-1:0]       nr_m1;
   logic [NCW-1:0]       nc_m1;
   logic [PXR-1:0]       rlim;
   logic [PXC-1:0]       clim;
   logic                 samp_ok;
   logic [PXR-1:0]       rl_full;
   logic [PXC-1:0]       cl_full;
   logic [RW-1:0]        rl;
   logic [CW-1:0]        cl;
   logic [FRAC_BITS-1:0] beta;
   logic [FRAC_BITS-1:0] alpha;

   assign rp_x    = PXR'(req_row_pos);
   assign cp_x    = PXC'(req_col_pos);
   assign nr_m1   = nr - NRW'(1);
   assign nc_m1   = nc - NCW'(1);
   assign rlim    = PXR'(nr_m1) << FRAC_BITS;
   assign clim    = PXC'(nc_m1) << FRAC_BITS;
   assign samp_ok = (nr != '0) && (nc != '0) && (rp_x <= rlim) && (cp_x <= clim);
   assign rl_full = rp_x >> FRAC_BITS;
   assign cl_full = cp_x >> FRAC_BITS;
   assign rl      = rl_full[RW-1:0];
   assign cl      = cl_full[CW-1:0];
   assign beta    = rp_x[FRAC_BITS-1:0];
   assign alpha   = cp_x[FRAC_BITS-1:0];

   // Status toward the controller.
   logic out_free;
   logic item_ok;

   assign out_free         = !rsp_tvalid || rsp_tready;
   assign status.go_read   = (req_op == OP_READ) && rw_ok;
   assign status.go_sample = (req_op == OP_SAMPLE) && samp_ok;
   assign status.out_free  = out_free;

   always_comb begin
      unique case (req_op)
         OP_WRITE:  item_ok = rw_ok;
         OP_READ:   item_ok = rw_ok;
         OP_SAMPLE: item_ok = samp_ok;
         default:   item_ok = 1'b0;
      endcase
   end

   // Transaction capture.
   logic [OP_W-1:0]      op_ff;
   logic                 ok_ff;
   logic [AW-1:0]        addr_ff;
   logic [RW-1:0]        rl_ff;
   logic [RW-1:0]        rh_ff;
   logic [CW-1:0]        cl_ff;
   logic [CW-1:0]        ch_ff;
   logic [FRAC_BITS-1:0] beta_ff;
   logic [FRAC_BITS-1:0] alpha_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_op;
         ok_ff    <= item_ok;
         addr_ff  <= {row_idx, col_idx};
         rl_ff    <= rl;
         rh_ff    <= rl + RW'(beta != '0);
         cl_ff    <= cl;
         ch_ff    <= cl + CW'(alpha != '0);
         beta_ff  <= beta;
         alpha_ff <= alpha;
      end
   end

   // Sample store: one write port, one registered read port.
   logic [SAMPLE_BITS-1:0]        store_mem [DEPTH];
   logic                          wr_en;
   logic signed [EXW-1:0]         val_ext;
   logic [AW-1:0]                 rd_addr;
   logic [RW-1:0]                 r_sel;
   logic [CW-1:0]                 c_sel;
   logic signed [SAMPLE_BITS-1:0] rdata_ff;

   assign wr_en   = cmd.capture && (req_op == OP_WRITE) && rw_ok;
   assign val_ext = EXW'(req_value);
   assign r_sel   = cmd.nbr[1] ? rh_ff : rl_ff;
   assign c_sel   = cmd.nbr[0] ? ch_ff : cl_ff;
   assign rd_addr = (op_ff == OP_SAMPLE) ? {r_sel, c_sel} : addr_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_mem[{row_idx, col_idx}] <= val_ext[SAMPLE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rdata_ff <= store_mem[rd_addr];
      end
   end

   // Weight of the cell being read: row weight times column weight.
   logic [WTW-1:0] wy;
   logic [WTW-1:0] wx;
   logic [WPW-1:0] weight_in;
   logic [WPW-1:0] weight_ff;

   assign wy        = cmd.nbr[1] ? WTW'(beta_ff) : (WT_ONE - WTW'(beta_ff));
   assign wx        = cmd.nbr[0] ? WTW'(alpha_ff) : (WT_ONE - WTW'(alpha_ff));
   assign weight_in = WPW'(wy) * WPW'(wx);

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         weight_ff <= weight_in;
      end
   end

   // Weighted sample product, then accumulation.
   logic signed [PRW-1:0]  w_s;
   logic signed [PRW-1:0]  s_s;
   logic signed [PRW-1:0]  prod_ff;
   logic signed [ACCW-1:0] acc_ff;

   assign w_s = signed'(PRW'(weight_ff));
   assign s_s = PRW'(rdata_ff);

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= w_s * s_s;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         acc_ff <= '0;
      end else if (cmd.acc_en) begin
         acc_ff <= acc_ff + ACCW'(prod_ff);
      end
   end

   // Result selection; the arithmetic shift floors the weighted sum.
   logic signed [ACCW-1:0]  samp_sh;
   logic signed [EXW-1:0]   rd_ext;
   logic signed [RES_W-1:0] result_in;

   assign samp_sh = acc_ff >>> (2 * FRAC_BITS);
   assign rd_ext  = EXW'(rdata_ff);

   always_comb begin
      result_in = '0;
      if (ok_ff) begin
         unique case (op_ff)
            OP_READ:   result_in = rd_ext[RES_W-1:0];
            OP_SAMPLE: result_in = samp_sh[RES_W-1:0];
            default:   result_in = '0;
         endcase
      end
   end

   // Output register.
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic signed [RES_W-1:0] rsp_result_ff;
   logic                    rsp_ok_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_result_ff <= result_in;
         rsp_ok_ff     <= ok_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;
   assign rsp_ok     = rsp_ok_ff;

endmodule
